// File: hdl/mri_pkg.sv
// Package for the midpoint-radius interval ALU: payload structs, op codes,
// pipeline stage types and the saturation helpers. No dependencies.
`timescale 1ns / 1ps

package mri_pkg;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_NEG  = 3'd4;
    localparam logic [2:0] OP_NORM = 3'd5;

    // Quotient bits kept by each divider; a larger quotient always saturates.
    localparam int DIV_STEPS = 33;

    localparam logic [63:0] VAL_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h0000_0000_8000_0000;
    localparam logic [63:0] RAD_MAX = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] a_value;
        logic [30:0]        a_radius;
        logic signed [31:0] b_value;
        logic [30:0]        b_radius;
    } mri_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [30:0]        result_radius;
        logic               less;
        logic               greater;
        logic               equal;
        logic               saturated;
        logic               div_zero;
    } mri_out_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } mri_sv_t;

    typedef struct packed {
        logic [30:0] radius;
        logic        sat;
    } mri_sr_t;

    // Result of the non-divide ops and the flags that ride along the divider
    typedef struct packed {
        logic [31:0] value;
        logic [30:0] radius;
        logic        sat;
        logic        is_div;
        logic        dz;
        logic        neg;
        logic        ovf_v;
        logic        ovf_1;
        logic        ovf_2;
        logic        less;
        logic        greater;
    } mri_side_t;

    // Three restoring dividers: value (a<<16)/b, radius term ra<<16/b,
    // radius term a*rb<<16/b^2
    typedef struct packed {
        mri_side_t   side;
        logic [31:0] bmag;
        logic [63:0] bsq;
        logic [31:0] rv;
        logic [31:0] r1;
        logic [63:0] r2;
        logic [32:0] nv;
        logic [32:0] n1;
        logic [32:0] n2;
        logic [32:0] qv;
        logic [32:0] q1;
        logic [32:0] q2;
    } mri_div_t;

    function automatic mri_sv_t sat_val(input logic neg, input logic [63:0] mag);
        mri_sv_t r;
        r.sat = 1'b0;
        if (!neg && mag > VAL_MAX) begin
            r.value = 32'h7FFF_FFFF;
            r.sat   = 1'b1;
        end else if (neg && mag > NEG_MAX) begin
            r.value = 32'h8000_0000;
            r.sat   = 1'b1;
        end else if (neg) begin
            r.value = 32'd0 - mag[31:0];
        end else begin
            r.value = mag[31:0];
        end
        return r;
    endfunction

    function automatic mri_sr_t sat_rad(input logic [63:0] rad);
        mri_sr_t r;
        if (rad > RAD_MAX) begin
            r.radius = 31'h7FFF_FFFF;
            r.sat    = 1'b1;
        end else begin
            r.radius = rad[30:0];
            r.sat    = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: hdl/mri_front.sv
// Front of the interval ALU pipeline: magnitudes, products and ordering flags,
// then the non-divide op results and the divider setup. Uses mri_pkg.
`timescale 1ns / 1ps

module mri_front
    import mri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  mri_in_t     cmd,
    input  logic [15:0] rel_eps,
    output logic        div_vld,
    output mri_div_t    div
);

    // stage A combinational
    logic [31:0] amag;
    logic [31:0] bmag;
    logic [32:0] sum;
    logic signed [33:0] a_hi;
    logic signed [33:0] a_lo;
    logic signed [33:0] b_hi;
    logic signed [33:0] b_lo;

    // stage A registers
    logic        a_vld_reg;
    logic [2:0]  op_reg;
    logic [31:0] av_reg;
    logic [30:0] ra_reg;
    logic [30:0] rb_reg;
    logic [31:0] amag_reg;
    logic [31:0] bmag_reg;
    logic [32:0] sum_reg;
    logic        less_reg;
    logic        greater_reg;
    logic        neg_reg;
    logic        bzero_reg;
    logic [63:0] pm_reg;
    logic [62:0] rab_reg;
    logic [62:0] rba_reg;
    logic [47:0] ep_reg;
    logic [63:0] bsq_reg;

    // stage B combinational
    mri_side_t   side;
    mri_sv_t     sv;
    mri_sr_t     sr;
    mri_div_t    div_next;
    logic [32:0] sum_mag;
    logic [63:0] rnd;
    logic [64:0] mrad;
    logic [48:0] eps_sum;
    logic [32:0] eps_rad;
    logic [32:0] rmax;
    logic [31:0] rsum;

    logic        div_vld_reg;
    mri_div_t    div_reg;

    always_comb
    begin
        amag = cmd.a_value[31] ? 32'd0 - cmd.a_value : cmd.a_value;
        bmag = cmd.b_value[31] ? 32'd0 - cmd.b_value : cmd.b_value;
        if (cmd.op == OP_SUB)
            sum = {cmd.a_value[31], cmd.a_value} - {cmd.b_value[31], cmd.b_value};
        else
            sum = {cmd.a_value[31], cmd.a_value} + {cmd.b_value[31], cmd.b_value};
        a_hi = {{2{cmd.a_value[31]}}, cmd.a_value} + {3'b0, cmd.a_radius};
        a_lo = {{2{cmd.a_value[31]}}, cmd.a_value} - {3'b0, cmd.a_radius};
        b_hi = {{2{cmd.b_value[31]}}, cmd.b_value} + {3'b0, cmd.b_radius};
        b_lo = {{2{cmd.b_value[31]}}, cmd.b_value} - {3'b0, cmd.b_radius};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= cmd.op;
        av_reg      <= cmd.a_value;
        ra_reg      <= cmd.a_radius;
        rb_reg      <= cmd.b_radius;
        amag_reg    <= amag;
        bmag_reg    <= bmag;
        sum_reg     <= sum;
        less_reg    <= a_hi < b_lo;
        greater_reg <= b_hi < a_lo;
        neg_reg     <= cmd.a_value[31] ^ cmd.b_value[31];
        bzero_reg   <= (cmd.b_value == 32'sd0);
        pm_reg      <= amag * bmag;
        rab_reg     <= cmd.a_radius * bmag;
        rba_reg     <= cmd.b_radius * amag;
        ep_reg      <= rel_eps * amag;
        bsq_reg     <= bmag * bmag;
    end

    always_comb
    begin
        sum_mag = sum_reg[32] ? 33'd0 - sum_reg : sum_reg;
        rnd     = pm_reg + 64'h8000;
        mrad    = {2'b0, rab_reg} + {2'b0, rba_reg} + 65'hFFFF;
        eps_sum = {1'b0, ep_reg} + 49'hFFFF;
        eps_rad = eps_sum[48:16];
        rmax    = (eps_rad > {2'b0, ra_reg}) ? eps_rad : {2'b0, ra_reg};
        rsum    = {1'b0, ra_reg} + {1'b0, rb_reg};
        sv      = '0;
        sr      = '0;
        side    = '0;
        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                sv = sat_val(sum_reg[32], {31'b0, sum_mag});
                sr = sat_rad({32'b0, rsum});
            end
            OP_MUL:
            begin
                sv = sat_val(neg_reg, {16'b0, rnd[63:16]});
                sr = sat_rad({15'b0, mrad[64:16]});
            end
            OP_DIV:
            begin
                sv = '0;
                sr = '0;
            end
            OP_NEG:
            begin
                sv = sat_val(!av_reg[31] && (av_reg != 32'd0), {32'b0, amag_reg});
                sr = sat_rad({31'b0, rmax});
            end
            OP_NORM:
            begin
                sv.value = av_reg;
                sv.sat   = 1'b0;
                sr = sat_rad({31'b0, rmax});
            end
            default:
            begin
                sv.value  = av_reg;
                sv.sat    = 1'b0;
                sr.radius = ra_reg;
                sr.sat    = 1'b0;
            end
        endcase
        side.value   = sv.value;
        side.radius  = sr.radius;
        side.sat     = sv.sat | sr.sat;
        side.is_div  = (op_reg == OP_DIV);
        side.dz      = bzero_reg;
        side.neg     = neg_reg;
        side.less    = less_reg;
        side.greater = greater_reg;
        // quotient fits DIV_STEPS bits only when the high numerator part is below the divisor
        side.ovf_v   = ({17'b0, amag_reg[31:17]} >= bmag_reg);
        side.ovf_1   = ({18'b0, ra_reg[30:17]} >= bmag_reg);
        side.ovf_2   = ({18'b0, rba_reg[62:17]} >= bsq_reg);

        div_next.side = side;
        div_next.bmag = bmag_reg;
        div_next.bsq  = bsq_reg;
        div_next.rv   = {17'b0, amag_reg[31:17]};
        div_next.r1   = {18'b0, ra_reg[30:17]};
        div_next.r2   = {18'b0, rba_reg[62:17]};
        div_next.nv   = {amag_reg[16:0], 16'b0};
        div_next.n1   = {ra_reg[16:0], 16'b0};
        div_next.n2   = {rba_reg[16:0], 16'b0};
        div_next.qv   = '0;
        div_next.q1   = '0;
        div_next.q2   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_vld_reg <= 1'b0;
        else
            div_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    assign div_vld = div_vld_reg;
    assign div     = div_reg;

endmodule

// File: hdl/mri_div_step.sv
// One registered quotient bit for the three restoring dividers of the
// interval ALU. Uses mri_pkg.
`timescale 1ns / 1ps

module mri_div_step
    import mri_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     vld_in,
    input  mri_div_t d_in,
    output logic     vld_out,
    output mri_div_t d_out
);

    logic [32:0] xv;
    logic [32:0] x1;
    logic [64:0] x2;
    logic [32:0] dv;
    logic [32:0] d1;
    logic [64:0] d2;
    logic        gv;
    logic        g1;
    logic        g2;
    mri_div_t    d_next;
    logic        vld_reg;
    mri_div_t    d_reg;

    always_comb
    begin
        // shift in the next numerator bit, subtract where it fits
        xv = {d_in.rv, d_in.nv[32]};
        x1 = {d_in.r1, d_in.n1[32]};
        x2 = {d_in.r2, d_in.n2[32]};
        gv = xv >= {1'b0, d_in.bmag};
        g1 = x1 >= {1'b0, d_in.bmag};
        g2 = x2 >= {1'b0, d_in.bsq};
        dv = xv - {1'b0, d_in.bmag};
        d1 = x1 - {1'b0, d_in.bmag};
        d2 = x2 - {1'b0, d_in.bsq};
        d_next    = d_in;
        d_next.rv = gv ? dv[31:0] : xv[31:0];
        d_next.r1 = g1 ? d1[31:0] : x1[31:0];
        d_next.r2 = g2 ? d2[63:0] : x2[63:0];
        d_next.qv = {d_in.qv[31:0], gv};
        d_next.q1 = {d_in.q1[31:0], g1};
        d_next.q2 = {d_in.q2[31:0], g2};
        d_next.nv = {d_in.nv[31:0], 1'b0};
        d_next.n1 = {d_in.n1[31:0], 1'b0};
        d_next.n2 = {d_in.n2[31:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule

// File: hdl/midpoint_radius_interval_alu.sv
// Top level of the midpoint-radius interval ALU: input register, front stages,
// divider chain, result select and output register. Uses mri_pkg.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive cmd and raise start; a transaction is taken at each
//   rising edge with start high and busy low. busy stays low, so a new command
//   may enter in every cycle.
//   Result channel: done is high for exactly one cycle with the matching result
//   on the result port; a result leaves after passing the input register, two
//   front stages, 33 divider bit stages and the output register. The latency
//   is the same for every op code, so results come out in command order at one
//   per cycle. The receiver cannot hold results off.
//   Configuration: cfg_data is written into rel_eps when cfg_valid and
//   cfg_ready are high at a rising edge; cfg_ready is always high. Write it
//   only while no command is in flight.
//   Reset: rst_n low clears all valid bits, so no done is raised for work
//   in flight, and sets rel_eps to 1.
module midpoint_radius_interval_alu
    import mri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  mri_in_t     cmd,
    output logic        done,
    output mri_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        in_vld_reg;
    mri_in_t     cmd_reg;
    logic [15:0] eps_reg;

    logic                 stg_vld [0:DIV_STEPS];
    mri_div_t             stg     [0:DIV_STEPS];

    mri_div_t    fin;
    mri_sv_t     fsv;
    mri_sr_t     fsr;
    logic [34:0] rsum;
    mri_out_t    out_next;
    logic        out_vld_reg;
    mri_out_t    out_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            eps_reg    <= 16'd1;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            if (cfg_valid && cfg_ready)
                eps_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd;
    end

    mri_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld_reg),
        .cmd     (cmd_reg),
        .rel_eps (eps_reg),
        .div_vld (stg_vld[0]),
        .div     (stg[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        mri_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (stg_vld[i]),
            .d_in    (stg[i]),
            .vld_out (stg_vld[i+1]),
            .d_out   (stg[i+1])
        );
    end

    always_comb
    begin
        fin  = stg[DIV_STEPS];
        rsum = {2'b0, fin.q1} + {34'b0, (fin.r1 != 32'd0)}
             + {2'b0, fin.q2} + {34'b0, (fin.r2 != 64'd0)};
        fsv  = sat_val(fin.side.neg, {31'b0, fin.qv});
        fsr  = sat_rad({29'b0, rsum});
        if (fin.side.ovf_v)
            fsv = sat_val(fin.side.neg, 64'hFFFF_FFFF);
        if (fin.side.ovf_1 || fin.side.ovf_2)
            fsr = sat_rad(64'hFFFF_FFFF);

        out_next.less    = fin.side.less;
        out_next.greater = fin.side.greater;
        out_next.equal   = !fin.side.less && !fin.side.greater;
        out_next.div_zero = fin.side.is_div && fin.side.dz;
        if (!fin.side.is_div)
        begin
            out_next.result_value  = fin.side.value;
            out_next.result_radius = fin.side.radius;
            out_next.saturated     = fin.side.sat;
        end
        else if (fin.side.dz)
        begin
            out_next.result_value  = 32'sd0;
            out_next.result_radius = 31'd0;
            out_next.saturated     = 1'b0;
        end
        else
        begin
            out_next.result_value  = fsv.value;
            out_next.result_radius = fsr.radius;
            out_next.saturated     = fsv.sat | fsr.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= stg_vld[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done   = out_vld_reg;
    assign result = out_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##37 done)
        else $error("command did not produce a result after 37 cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 37))
        else $error("result without a matching command");

    a_order_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.less && result.greater)
                 && (result.equal == !(result.less || result.greater)))
        else $error("inconsistent ordering flags");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.div_zero |-> result.result_value == 32'sd0
                 && result.result_radius == 31'd0 && !result.saturated)
        else $error("divide by zero result not cleared");

endmodule

// File: tb/sv/tb_midpoint_radius_interval_alu.sv
// Self-checking testbench for midpoint_radius_interval_alu: predicts each
// interval result in SV and compares it with the done-strobed result port.
// Depends on mri_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_midpoint_radius_interval_alu;
    import mri_pkg::*;

    localparam int LATENCY = 37;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    mri_in_t     cmd;
    logic        done;
    mri_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    logic [15:0] eps_model;
    mri_out_t    pending_results[$];
    int          error_count;
    int          item_count;
    int          result_count;

    midpoint_radius_interval_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_midpoint_radius_interval_alu: errors");
        $finish;
    end

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void clip_value(input logic neg, input logic [63:0] mag,
                                       output logic [31:0] v, inout logic sat);
        if (!neg && mag > 64'h7FFF_FFFF)
        begin
            v = 32'h7FFF_FFFF;
            sat = 1'b1;
        end
        else if (neg && mag > 64'h8000_0000)
        begin
            v = 32'h8000_0000;
            sat = 1'b1;
        end
        else
            v = neg ? 32'd0 - mag[31:0] : mag[31:0];
    endfunction

    function automatic void clip_radius(input logic [63:0] r, output logic [30:0] o,
                                        inout logic sat);
        if (r > 64'h7FFF_FFFF)
        begin
            o = 31'h7FFF_FFFF;
            sat = 1'b1;
        end
        else
            o = r[30:0];
    endfunction

    // ceil(n * 2^16 / d); returns 2^32 when n / d is at least 2^31
    function automatic logic [63:0] ceil_frac_div(input logic [63:0] n,
                                                   input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = n / d;
        r = n % d;
        if (q >= 64'h8000_0000)
            return 64'h1_0000_0000;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return (r != 0) ? q + 1 : q;
    endfunction

    function automatic logic [63:0] widened_radius(input logic [63:0] ra,
                                                   input logic [63:0] amag);
        logic [63:0] e;
        e = ({48'd0, eps_model} * amag + 64'hFFFF) >> 16;
        return e > ra ? e : ra;
    endfunction

    function automatic mri_out_t predict_interval(input mri_in_t c);
        mri_out_t o;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] s;
        logic [63:0] ra;
        logic [63:0] rb;
        logic [63:0] amag;
        logic [63:0] bmag;
        logic        sat;
        logic        neg;
        a = c.a_value;
        b = c.b_value;
        ra = {33'd0, c.a_radius};
        rb = {33'd0, c.b_radius};
        amag = abs64(a);
        bmag = abs64(b);
        sat = 1'b0;
        o = '0;
        neg = (a < 0) != (b < 0);
        case (c.op)
            OP_ADD, OP_SUB:
            begin
                s = (c.op == OP_ADD) ? a + b : a - b;
                clip_value(s < 0, abs64(s), o.result_value, sat);
                clip_radius(ra + rb, o.result_radius, sat);
            end
            OP_MUL:
            begin
                clip_value(neg, (amag * bmag + 64'h8000) >> 16, o.result_value, sat);
                clip_radius((ra * bmag + rb * amag + 64'hFFFF) >> 16, o.result_radius, sat);
            end
            OP_DIV:
            begin
                if (b == 0)
                    o.div_zero = 1'b1;
                else
                begin
                    clip_value(neg, (amag << 16) / bmag, o.result_value, sat);
                    clip_radius(ceil_frac_div(ra, bmag) +
                                ceil_frac_div(amag * rb, bmag * bmag),
                                o.result_radius, sat);
                end
            end
            OP_NEG:
            begin
                clip_value(a > 0, amag, o.result_value, sat);
                clip_radius(widened_radius(ra, amag), o.result_radius, sat);
            end
            OP_NORM:
            begin
                o.result_value = c.a_value;
                clip_radius(widened_radius(ra, amag), o.result_radius, sat);
            end
            default:
            begin
                o.result_value = c.a_value;
                o.result_radius = c.a_radius;
            end
        endcase
        o.less = (a + $signed(ra)) < (b - $signed(rb));
        o.greater = (b + $signed(rb)) < (a - $signed(ra));
        o.equal = !o.less && !o.greater;
        o.saturated = sat;
        return o;
    endfunction

    // Compare each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                mri_out_t e;
                e = pending_results.pop_front();
                result_count++;
                if (result.result_value !== e.result_value)
                begin
                    $error("result_value exp %h got %h", e.result_value, result.result_value);
                    error_count++;
                end
                if (result.result_radius !== e.result_radius)
                begin
                    $error("result_radius exp %h got %h", e.result_radius,
                           result.result_radius);
                    error_count++;
                end
                if (result.less !== e.less)
                begin
                    $error("less exp %b got %b", e.less, result.less);
                    error_count++;
                end
                if (result.greater !== e.greater)
                begin
                    $error("greater exp %b got %b", e.greater, result.greater);
                    error_count++;
                end
                if (result.equal !== e.equal)
                begin
                    $error("equal exp %b got %b", e.equal, result.equal);
                    error_count++;
                end
                if (result.saturated !== e.saturated)
                begin
                    $error("saturated exp %b got %b", e.saturated, result.saturated);
                    error_count++;
                end
                if (result.div_zero !== e.div_zero)
                begin
                    $error("div_zero exp %b got %b", e.div_zero, result.div_zero);
                    error_count++;
                end
            end
        end
    end

    task automatic send_interval(input mri_in_t c);
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_interval(c));
        item_count++;
    endtask

    task automatic pause_sender();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_eps(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        eps_model = v;
        @(posedge clk);
    endtask

    function automatic mri_in_t make_item(input logic [2:0] op, input logic [31:0] a,
                                          input logic [30:0] ra, input logic [31:0] b,
                                          input logic [30:0] rb);
        mri_in_t c;
        c.op = op;
        c.a_value = a;
        c.a_radius = ra;
        c.b_value = b;
        c.b_radius = rb;
        return c;
    endfunction

    // Mostly moderate magnitudes so results rarely clip; some full-range values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'd0;
            default: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000) >>> $urandom_range(0, 12);
        endcase
    endfunction

    function automatic logic [30:0] pick_radius();
        case ($urandom_range(0, 7))
            0: return 31'($urandom());
            1: return 31'd0;
            2: return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(0, 32'h0010_0000) >> $urandom_range(0, 16));
        endcase
    endfunction

    task automatic test_directed_edges();
        logic [2:0] ops[8] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_NORM,
                               3'd6, 3'd7};
        foreach (ops[i])
            send_interval(make_item(ops[i], 32'h0003_8000, 31'h100, 32'hFFFE_0000, 31'h80));
        send_interval(make_item(OP_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                31'h7FFF_FFFF));
        send_interval(make_item(OP_SUB, 32'h8000_0000, 31'd0, 32'h7FFF_FFFF, 31'd0));
        send_interval(make_item(OP_MUL, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000,
                                31'h7FFF_FFFF));
        send_interval(make_item(OP_MUL, 32'hFFFF_8000, 31'd1, 32'h0000_0001, 31'd1));
        // divide by zero
        send_interval(make_item(OP_DIV, 32'h1234_5678, 31'h55, 32'd0, 31'h10));
        send_interval(make_item(OP_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF));
        send_interval(make_item(OP_DIV, 32'h7FFF_FFFF, 31'd1, 32'hFFFF_FFFF, 31'd0));
        // negate of the most negative value clips
        send_interval(make_item(OP_NEG, 32'h8000_0000, 31'd0, 32'd0, 31'd0));
        send_interval(make_item(OP_NORM, 32'h7FFF_FFFF, 31'd0, 32'd5, 31'd0));
        send_interval(make_item(OP_NORM, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'd0, 31'd0));
        // ordering: touching, strictly less, strictly greater
        send_interval(make_item(3'd6, 32'd10, 31'd5, 32'd20, 31'd5));
        send_interval(make_item(3'd7, 32'd10, 31'd4, 32'd20, 31'd5));
        send_interval(make_item(OP_ADD, 32'd30, 31'd4, 32'd20, 31'd5));
        drain_results();
    endtask

    task automatic test_random_traffic(input int n);
        mri_in_t c;
        int burst;
        int sent;
        sent = 0;
        while (sent < n)
        begin
            burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n; i++)
            begin
                c = make_item(3'($urandom_range(0, 7)), pick_value(), pick_radius(),
                              pick_value(), pick_radius());
                if (c.op > OP_NORM && $urandom_range(0, 3) != 0)
                    c.op = 3'($urandom_range(0, 5));
                send_interval(c);
                sent++;
            end
            repeat ($urandom_range(0, 5)) pause_sender();
        end
        drain_results();
    endtask

    task automatic test_eps_settings();
        logic [15:0] settings[4] = '{16'hFFFF, 16'd0, 16'h8000, 16'h0123};
        foreach (settings[i])
        begin
            write_eps(settings[i]);
            send_interval(make_item(OP_NEG, 32'h8000_0000, 31'd0, 32'd0, 31'd0));
            send_interval(make_item(OP_NORM, 32'h7FFF_FFFF, 31'd3, 32'd0, 31'd0));
            test_random_traffic(150);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        eps_model = 16'd1;
        error_count = 0;
        item_count = 0;
        result_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic(150);
        test_eps_settings();

        $display("Covered %0d commands over all op codes and four rel_eps settings;",
                 item_count);
        $display("%0d results compared field by field.", result_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_midpoint_radius_interval_alu: clean");
        else
            $display("tb_midpoint_radius_interval_alu: errors");
        $finish;
    end

endmodule
